[src/ple_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 9;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 9;

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

  // result status
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  // work plan handed from the front end to the walker
  typedef struct packed {
    logic            start;
    logic            walk;  // sweep a range of stored entries
    logic            put;   // write the new value after the sweep
    logic [OP_W-1:0] op;
  } ple_plan_t;

  // walker completion
  typedef struct packed {
    logic              done;
    logic              found;
    logic [DATA_W-1:0] rd_data;
  } ple_wres_t;

endpackage

`default_nettype wire

[src/ple_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ple_in_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, opcode, position, item_value, input ready);
  modport sink   (input valid, opcode, position, item_value, output ready);
endinterface

`default_nettype wire

[src/ple_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ple_out_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] read_value;
  logic                     found;
  logic [CNT_OUT_W-1:0]     count;

  modport source (output valid, status, read_value, found, count, input ready);
  modport sink   (input valid, status, read_value, found, count, output ready);
endinterface

`default_nettype wire

[src/ple_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/ple_walker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ple_walker #(
  parameter int DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ple_pkg::ple_plan_t            plan,
  input  wire logic [$clog2(DEPTH)-1:0]      first,
  input  wire logic [$clog2(DEPTH)-1:0]      last,
  input  wire logic [$clog2(DEPTH)-1:0]      put_addr,
  input  wire logic [ple_pkg::DATA_W-1:0]    value,
  input  wire logic                          take,
  output ple_pkg::ple_wres_t                 wres
);
  import ple_pkg::*;

  localparam int AW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     last_r;
  logic [AW-1:0]     put_r;
  logic [AW-1:0]     pend_addr;
  logic              pend_v;
  logic [DATA_W-1:0] val_r;
  logic [OP_W-1:0]   op_r;
  logic              put_f;
  logic              found_r;
  logic [DATA_W-1:0] rd_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;
  logic              move;

  ple_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr),
    .rdata (rdata)
  );

  // entry read last cycle moves one slot: up for insert, down for remove
  assign move = pend_v && (op_r == OP_INSERT || op_r == OP_REMOVE);

  always_comb begin
    we    = 1'b0;
    waddr = pend_addr;
    wdata = rdata;
    if (state == S_PUT) begin
      we    = 1'b1;
      waddr = put_r;
      wdata = val_r;
    end else if (move) begin
      we    = 1'b1;
      waddr = (op_r == OP_INSERT) ? pend_addr + AW'(1) : pend_addr - AW'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (plan.start) begin
          if (plan.walk) begin
            state_next = S_WALK;
          end else if (plan.put) begin
            state_next = S_PUT;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_WALK: begin
        if (ptr == last_r) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = put_f ? S_PUT : S_FIN;
      S_PUT:   state_next = S_FIN;
      S_FIN: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      pend_v <= (state == S_WALK);
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= ptr;
    if (state == S_IDLE && plan.start) begin
      ptr     <= first;
      last_r  <= last;
      put_r   <= put_addr;
      val_r   <= value;
      op_r    <= plan.op;
      put_f   <= plan.put;
      found_r <= 1'b0;
      rd_r    <= '0;
    end else begin
      if (state == S_WALK && ptr != last_r) begin
        ptr <= (op_r == OP_INSERT) ? ptr - AW'(1) : ptr + AW'(1);
      end
      if (pend_v && op_r == OP_SEARCH && rdata == val_r) begin
        found_r <= 1'b1;
      end
      if (pend_v && op_r == OP_READ) begin
        rd_r <= rdata;
      end
    end
  end

  assign wres.done    = (state == S_FIN);
  assign wres.found   = found_r;
  assign wres.rd_data = rd_r;

endmodule

`default_nettype wire

[src/positional_list_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Steps from accept to result: an error, a search of an empty list or a remove of the last
// entry go straight to the result; an insert at the tail only writes the new value; else the
// stored entries are swept (a read sweeps one), and an insert then writes the new value.
// Throughput: one transaction at a time; the next one is taken the cycle after the result
// is loaded. The sweep moves one entry per cycle through the single RAM port pair.
// Reset (rst, synchronous) empties the list; RAM contents are left as they are.

module positional_list_engine_core #(
  parameter int DEPTH = 256
) (
  input wire logic clk,
  input wire logic rst,
  ple_in_if.sink   req,
  ple_out_if.source rsp
);
  import ple_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  // control
  logic            busy;
  logic [CW-1:0]   entry_count;
  logic [CW-1:0]   entry_count_next;
  logic [ST_W-1:0] st_r;
  logic [OP_W-1:0] op_r;

  // result register
  logic                     out_valid;
  logic [ST_W-1:0]          out_status;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     out_found;
  logic [CNT_OUT_W-1:0]     out_count;

  // decode
  logic            accept;
  logic            take;
  logic [PW-1:0]   pos_x;
  logic [PW-1:0]   cnt_x;
  logic [PW-1:0]   pos_m1;
  logic [CW-1:0]   cnt_m1;
  logic            ins_bad;
  logic            rr_bad;
  logic            full;
  logic [ST_W-1:0] st;
  ple_plan_t       plan;
  logic [AW-1:0]   first;
  logic [AW-1:0]   last;
  logic [AW-1:0]   put_addr;
  ple_wres_t       wres;
  logic [CW+CNT_OUT_W-1:0] cnt_wide;

  assign accept = req.valid && req.ready;
  assign take   = !out_valid || rsp.ready;

  assign pos_x   = PW'(req.position);
  assign cnt_x   = PW'(entry_count);
  assign pos_m1  = pos_x - PW'(1);
  assign cnt_m1  = entry_count - CW'(1);
  assign ins_bad = (req.position == '0) || (pos_x > cnt_x + PW'(1));
  assign rr_bad  = (req.position == '0) || (pos_x > cnt_x);
  assign full    = (entry_count == CW'(DEPTH));

  // Check the position, then plan the sweep. Insert sweeps from the tail down to the slot,
  // remove from the slot after the hole up to the tail, read one entry, search the whole list.
  always_comb begin
    st               = ST_OK;
    plan.start       = accept;
    plan.walk        = 1'b0;
    plan.put         = 1'b0;
    plan.op          = req.opcode;
    first            = cnt_m1[AW-1:0];
    last             = cnt_m1[AW-1:0];
    put_addr         = pos_m1[AW-1:0];
    entry_count_next = entry_count;
    unique case (req.opcode)
      OP_INSERT: begin
        if (ins_bad) begin
          st = ST_BADPOS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          plan.put         = 1'b1;
          plan.walk        = (pos_x <= cnt_x);  // slot not at the tail: shift up
          last             = pos_m1[AW-1:0];
          entry_count_next = entry_count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (rr_bad) begin
          st = ST_BADPOS;
        end else begin
          plan.walk        = (pos_x < cnt_x);   // not the last entry: close the gap
          first            = pos_x[AW-1:0];
          entry_count_next = entry_count - CW'(1);
        end
      end
      OP_READ: begin
        if (rr_bad) begin
          st = ST_BADPOS;
        end else begin
          plan.walk = 1'b1;
          first     = pos_m1[AW-1:0];
          last      = pos_m1[AW-1:0];
        end
      end
      OP_SEARCH: begin
        plan.walk = (entry_count != '0);
        first     = '0;
      end
      default: st = ST_OK;
    endcase
  end

  ple_walker #(.DEPTH(DEPTH)) u_walker (
    .clk      (clk),
    .rst      (rst),
    .plan     (plan),
    .first    (first),
    .last     (last),
    .put_addr (put_addr),
    .value    (req.item_value),
    .take     (take),
    .wres     (wres)
  );

  // count keeps its low bits on the port
  assign cnt_wide = {{CNT_OUT_W{1'b0}}, entry_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        busy        <= 1'b1;
        entry_count <= entry_count_next;
      end else if (wres.done && take) begin
        busy <= 1'b0;
      end
      if (wres.done && take) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= st;
      op_r <= req.opcode;
    end
    if (wres.done && take) begin
      out_status <= st_r;
      if (st_r != ST_OK) begin
        out_read_value <= '1;
      end else if (op_r == OP_READ) begin
        out_read_value <= wres.rd_data;
      end else begin
        out_read_value <= '0;
      end
      out_found <= wres.found;
      out_count <= cnt_wide[CNT_OUT_W-1:0];
    end
  end

  assign req.ready      = !busy;
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_read_value;
  assign rsp.found      = out_found;
  assign rsp.count      = out_count;

endmodule

`default_nettype wire
